FILE: rtl/okvt_pkg.sv
// Shared types and constants for the ordered key/value table.
`default_nettype none
package okvt_pkg;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } okvt_cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } okvt_state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             load;    // latch key compares for a new item
    logic             exec;    // apply the latched command
    okvt_cmd_t        cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] wval;
    logic             any_hit; // some cell matched the latched key
  } okvt_op_t;

  typedef struct packed {
    logic               hit;
    logic               inserted;
    logic               table_full;
    logic [VAL_W-1:0]   read_value;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] entry_count;
  } okvt_result_t;

endpackage
`default_nettype wire

FILE: rtl/okvt_if.sv
// Valid/ready channel interfaces for command items and result items.
`default_nettype none
interface okvt_in_if;
  import okvt_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key;
  logic [VAL_W-1:0]        write_value;

  modport source(output valid, output cmd, output key, output write_value, input ready);
  modport sink(input valid, input cmd, input key, input write_value, output ready);
endinterface

interface okvt_out_if;
  import okvt_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               inserted;
  logic               table_full;
  logic [VAL_W-1:0]   read_value;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] entry_count;

  modport source(output valid, output hit, output inserted, output table_full,
                 output read_value, output position, output entry_count, input ready);
  modport sink(input valid, input hit, input inserted, input table_full,
               input read_value, input position, input entry_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/ordered_key_value_table.sv
// Ordered key/value table: controller, result register and the row of slot cells.
//
// Each command item is accepted, then executed: in the cycle it is accepted every
// cell compares its key against the item's key and registers the outcome; in
// the update cycle the first match is resolved along the row of cells, the table
// is updated (value write, append, shift-down on delete, emptying on clear) and
// the result item is loaded into the output register. A new command is accepted
// the cycle after that, even while the previous result is still waiting on the
// output side; the update cycle waits only while the output register is still
// occupied. The ripple of the first-match flag through CAPACITY cells sets the
// length of the update cycle. Entries stay in insertion order in slots 0 up to
// the entry count minus one; position and entry_count are reported in 4 and 5
// bits respectively.
`default_nettype none
module ordered_key_value_table import okvt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  okvt_in_if.sink    in_ch,
  okvt_out_if.source out_ch
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  okvt_state_t      state_r, state_nxt;
  logic             in_ready;
  logic             exec_go;
  logic             in_acc;

  okvt_cmd_t        cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] wval_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  okvt_result_t     res_r, res_nxt;
  logic             out_valid_r;

  okvt_op_t         op;
  logic [CAPACITY:0]   seen_chain;
  logic [CAPACITY:0]   valid_chain;
  logic [CAPACITY-1:0] first_v;
  logic [KEY_W-1:0]    key_a [CAPACITY];
  logic [VAL_W-1:0]    val_a [CAPACITY];

  logic             any_hit;
  logic [IDX_W-1:0] hit_pos;
  logic [VAL_W-1:0] hit_val;
  logic             room;

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_EXEC;
      ST_EXEC: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    exec_go  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: exec_go  = !out_valid_r || out_ch.ready;
      default: begin
      end
    endcase
  end

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= okvt_cmd_t'(in_ch.cmd);
      key_r  <= in_ch.key;
      wval_r <= in_ch.write_value;
    end
  end

  // ---------------------------------------------------------------- cells
  always_comb begin
    op.load    = in_acc;
    op.exec    = exec_go;
    op.cmd     = cmd_r;
    op.key     = (state_r == ST_EXEC) ? key_r : in_ch.key;
    op.wval    = wval_r;
    op.any_hit = any_hit;
  end

  assign seen_chain[0]         = 1'b0;
  assign valid_chain[0]        = 1'b1;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             up_valid;
    logic [KEY_W-1:0] up_key;
    logic [VAL_W-1:0] up_val;

    if (i == CAPACITY - 1) begin : g_top
      assign up_valid = 1'b0;
      assign up_key   = key_a[i];
      assign up_val   = val_a[i];
    end else begin : g_mid
      assign up_valid = valid_chain[i+2];
      assign up_key   = key_a[i+1];
      assign up_val   = val_a[i+1];
    end

    okvt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .seen_in    (seen_chain[i]),
      .prev_valid (valid_chain[i]),
      .seen_out   (seen_chain[i+1]),
      .nxt_valid  (up_valid),
      .nxt_key    (up_key),
      .nxt_val    (up_val),
      .valid_o    (valid_chain[i+1]),
      .key_o      (key_a[i]),
      .val_o      (val_a[i]),
      .first_o    (first_v[i])
    );
  end

  // At most one cell reports the first match, so the lookups are plain OR trees.
  always_comb begin
    hit_pos = '0;
    hit_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_pos = hit_pos | (first_v[i] ? IDX_W'(i) : '0);
      hit_val = hit_val | (first_v[i] ? val_a[i] : '0);
    end
  end

  assign any_hit = seen_chain[CAPACITY];
  assign room    = count_r < CNT_W'(CAPACITY);

  // ---------------------------------------------------------------- result
  always_comb begin
    logic [IDX_W-1:0]   pos;
    logic [IDX_W+3:0]   pos_ext;
    logic [CNT_W+4:0]   cnt_ext;
    res_nxt   = '0;
    count_nxt = count_r;
    pos       = '0;
    case (cmd_r)
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      CMD_GET: begin
        res_nxt.hit = any_hit;
        if (any_hit) begin
          pos                = hit_pos;
          res_nxt.read_value = hit_val;
        end
      end
      CMD_DELETE: begin
        res_nxt.hit = any_hit;
        if (any_hit) begin
          pos       = hit_pos;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_SET: begin
        res_nxt.hit = any_hit;
        if (any_hit) begin
          pos = hit_pos;
        end else if (room) begin
          pos              = count_r[IDX_W-1:0];
          count_nxt        = count_r + CNT_W'(1);
          res_nxt.inserted = 1'b1;
        end else begin
          res_nxt.table_full = 1'b1;
        end
      end
      default: begin
      end
    endcase
    pos_ext             = {4'b0, pos};
    cnt_ext             = {5'b0, count_nxt};
    res_nxt.position    = pos_ext[POS_W-1:0];
    res_nxt.entry_count = cnt_ext[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (exec_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = res_r.hit;
  assign out_ch.inserted    = res_r.inserted;
  assign out_ch.table_full  = res_r.table_full;
  assign out_ch.read_value  = res_r.read_value;
  assign out_ch.position    = res_r.position;
  assign out_ch.entry_count = res_r.entry_count;

endmodule
`default_nettype wire

FILE: rtl/okvt_cell.sv
// One table slot: holds a key/value pair, compares it and shifts toward slot zero.
`default_nettype none
module okvt_cell import okvt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire okvt_op_t         op,
  input  wire logic             seen_in,    // a lower slot matched
  input  wire logic             prev_valid, // lower slot is occupied
  output logic                  seen_out,
  input  wire logic             nxt_valid,
  input  wire logic [KEY_W-1:0] nxt_key,
  input  wire logic [VAL_W-1:0] nxt_val,
  output logic                  valid_o,
  output logic [KEY_W-1:0]      key_o,
  output logic [VAL_W-1:0]      val_o,
  output logic                  first_o
);

  logic             valid_r, valid_nxt;
  logic             match_r, match_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             first;

  assign first    = match_r && !seen_in;
  assign seen_out = seen_in || match_r;
  assign first_o  = first;
  assign valid_o  = valid_r;
  assign key_o    = key_r;
  assign val_o    = val_r;

  always_comb begin
    valid_nxt = valid_r;
    match_nxt = match_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    if (op.load) begin
      match_nxt = valid_r && (key_r == op.key);
    end
    if (op.exec) begin
      case (op.cmd)
        CMD_CLEAR: begin
          valid_nxt = 1'b0;
        end
        CMD_DELETE: begin
          // The matching slot and every slot above it take their upper neighbor.
          if (seen_in || match_r) begin
            valid_nxt = nxt_valid;
            key_nxt   = nxt_key;
            val_nxt   = nxt_val;
          end
        end
        CMD_SET: begin
          if (first) begin
            val_nxt = op.wval;
          end else if (!op.any_hit && !valid_r && prev_valid) begin
            // First free slot takes the new pair.
            valid_nxt = 1'b1;
            key_nxt   = op.key;
            val_nxt   = op.wval;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/okvt_checker.sv
// Port-level checks for the ordered key/value table, bound to the top level.
`default_nettype none
module okvt_checker import okvt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               hit,
  input wire logic               inserted,
  input wire logic               table_full,
  input wire logic [VAL_W-1:0]   read_value,
  input wire logic [COUNT_W-1:0] entry_count
);

  // Each command needs its update cycle before the next one can enter.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("okvt: command accepted in the cycle after another");

  // A waiting result is not overwritten.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(read_value) && $stable(hit)))
    else $error("okvt: stalled result changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({hit, inserted, table_full}) <= 1))
    else $error("okvt: conflicting result flags");

  a_read_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (read_value != '0)) |-> hit)
    else $error("okvt: read value without a hit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((CAPACITY > 31) || (int'(entry_count) <= CAPACITY)))
    else $error("okvt: entry count beyond capacity");

endmodule

bind ordered_key_value_table okvt_checker #(.CAPACITY(CAPACITY)) u_okvt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .hit         (out_ch.hit),
  .inserted    (out_ch.inserted),
  .table_full  (out_ch.table_full),
  .read_value  (out_ch.read_value),
  .entry_count (out_ch.entry_count)
);
`default_nettype wire
